/* design/mpba_pkg.sv */
// Shared types for the multi-pool block allocator.
// Status and request codes plus the controller/datapath command and status structs.
// No dependencies.
package mpba_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_BAD_POOL  = 2'd2,
		ST_BAD_BLOCK = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		POOL_SMALL  = 2'd0,
		POOL_MEDIUM = 2'd1,
		POOL_LARGE  = 2'd2,
		POOL_BAD    = 2'd3
	} pool_t;

	// controller -> datapath
	typedef struct packed {
		logic    cap;        // capture the input item
		logic    scan_init;  // pointer := block after last granted
		logic    scan_next;  // advance pointer with wrap
		logic    grant;      // mark pointer block used
		logic    release_blk; // clear requested block
		logic    set_res;    // latch result status
		status_t res_code;
		logic    publish;    // load output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_pool;
		logic op_free;
		logic free_ok;
		logic cand_free;
		logic scan_last;
		logic out_busy;
	} stat_t;

endpackage

/* design/mpba_dp.sv */
// Datapath of the multi-pool block allocator: in-use bitmaps, pointers, counts,
// scan pointer and the output register. Driven by mpba_ctrl; uses mpba_pkg.
module mpba_dp import mpba_pkg::*; #(
	parameter int SMALL_BLOCKS  = 16,
	parameter int MEDIUM_BLOCKS = 8,
	parameter int LARGE_BLOCKS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  s_tuser,
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,
	output logic [23:0] m_tdata,
	input  cmd_t        cmd,
	output stat_t       stat
);

	localparam int SW = (SMALL_BLOCKS  > 1) ? $clog2(SMALL_BLOCKS)  : 1;
	localparam int MW = (MEDIUM_BLOCKS > 1) ? $clog2(MEDIUM_BLOCKS) : 1;
	localparam int LW = (LARGE_BLOCKS  > 1) ? $clog2(LARGE_BLOCKS)  : 1;
	localparam logic [8:0] N_S = 9'(SMALL_BLOCKS);
	localparam logic [8:0] N_M = 9'(MEDIUM_BLOCKS);
	localparam logic [8:0] N_L = 9'(LARGE_BLOCKS);

	op_t   op_q;
	pool_t pool_q;
	logic [7:0] blk_q;

	logic [SMALL_BLOCKS-1:0]  sm_map_q;
	logic [MEDIUM_BLOCKS-1:0] md_map_q;
	logic [LARGE_BLOCKS-1:0]  lg_map_q;
	logic [7:0] last_q [3];
	logic [8:0] cnt_q  [3];

	logic [7:0] ptr_q;
	logic [8:0] probe_q;

	status_t    res_code_q;
	logic [7:0] res_grant_q;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [7:0] out_grant_q;
	logic [8:0] out_rem_q;
	logic       out_full_q;

	logic [8:0] n_sel;
	logic [7:0] last_sel;
	logic [8:0] cnt_sel;
	logic [7:0] idx;
	logic       map_bit;
	logic       blk_in_range;
	logic [8:0] rem;

	function automatic logic [7:0] next_ptr(input logic [7:0] p, input logic [8:0] n);
		logic [8:0] p1;
		p1 = {1'b0, p} + 9'd1;
		return (p1 >= n) ? 8'd0 : p1[7:0];
	endfunction

	assign idx = (op_q == OP_FREE) ? blk_q : ptr_q;

	always_comb begin
		unique case (pool_q)
			POOL_SMALL: begin
				n_sel    = N_S;
				last_sel = last_q[0];
				cnt_sel  = cnt_q[0];
				map_bit  = sm_map_q[idx[SW-1:0]];
			end
			POOL_MEDIUM: begin
				n_sel    = N_M;
				last_sel = last_q[1];
				cnt_sel  = cnt_q[1];
				map_bit  = md_map_q[idx[MW-1:0]];
			end
			POOL_LARGE: begin
				n_sel    = N_L;
				last_sel = last_q[2];
				cnt_sel  = cnt_q[2];
				map_bit  = lg_map_q[idx[LW-1:0]];
			end
			default: begin
				n_sel    = 9'd0;
				last_sel = 8'd0;
				cnt_sel  = 9'd0;
				map_bit  = 1'b1;
			end
		endcase
	end

	assign blk_in_range = {1'b0, blk_q} < n_sel;
	assign rem = (pool_q == POOL_BAD) ? 9'd0 : n_sel - cnt_sel;

	assign stat.bad_pool  = (pool_q == POOL_BAD);
	assign stat.op_free   = (op_q == OP_FREE);
	assign stat.free_ok   = blk_in_range && map_bit;
	assign stat.cand_free = !map_bit;
	assign stat.scan_last = (probe_q == n_sel - 9'd1);
	assign stat.out_busy  = out_valid_q && !m_tready;

	// pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_map_q <= '0;
			md_map_q <= '0;
			lg_map_q <= '0;
			for (int i = 0; i < 3; i++) begin
				last_q[i] <= 8'd0;
				cnt_q[i]  <= 9'd0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.grant) begin
				unique case (pool_q)
					POOL_SMALL: begin
						sm_map_q[ptr_q[SW-1:0]] <= 1'b1;
						last_q[0] <= ptr_q;
						cnt_q[0]  <= cnt_q[0] + 9'd1;
					end
					POOL_MEDIUM: begin
						md_map_q[ptr_q[MW-1:0]] <= 1'b1;
						last_q[1] <= ptr_q;
						cnt_q[1]  <= cnt_q[1] + 9'd1;
					end
					POOL_LARGE: begin
						lg_map_q[ptr_q[LW-1:0]] <= 1'b1;
						last_q[2] <= ptr_q;
						cnt_q[2]  <= cnt_q[2] + 9'd1;
					end
					default: ;
				endcase
			end
			if (cmd.release_blk) begin
				unique case (pool_q)
					POOL_SMALL: begin
						sm_map_q[blk_q[SW-1:0]] <= 1'b0;
						cnt_q[0] <= cnt_q[0] - 9'd1;
					end
					POOL_MEDIUM: begin
						md_map_q[blk_q[MW-1:0]] <= 1'b0;
						cnt_q[1] <= cnt_q[1] - 9'd1;
					end
					POOL_LARGE: begin
						lg_map_q[blk_q[LW-1:0]] <= 1'b0;
						cnt_q[2] <= cnt_q[2] - 9'd1;
					end
					default: ;
				endcase
			end
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op_t'(s_tuser[0]);
			pool_q <= pool_t'(s_tuser[2:1]);
			blk_q  <= s_tdata;
		end
		if (cmd.scan_init) begin
			ptr_q   <= next_ptr(({1'b0, last_sel} >= n_sel) ? 8'd0 : last_sel, n_sel);
			probe_q <= 9'd0;
		end else if (cmd.scan_next) begin
			ptr_q   <= next_ptr(ptr_q, n_sel);
			probe_q <= probe_q + 9'd1;
		end
		if (cmd.set_res) begin
			res_code_q  <= cmd.res_code;
			res_grant_q <= cmd.grant ? ptr_q : 8'd0;
		end
		if (cmd.publish) begin
			out_status_q <= res_code_q;
			out_grant_q  <= res_grant_q;
			out_rem_q    <= rem;
			out_full_q   <= (rem == 9'd0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_full_q, out_rem_q, out_grant_q};

	// bitmap population always matches the in-use count
	a_small_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(sm_map_q) == int'(cnt_q[0]))
		else $error("small pool count out of step with bitmap");
	a_medium_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(md_map_q) == int'(cnt_q[1]))
		else $error("medium pool count out of step with bitmap");
	a_large_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(lg_map_q) == int'(cnt_q[2]))
		else $error("large pool count out of step with bitmap");
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> !map_bit && ({1'b0, ptr_q} < n_sel))
		else $error("grant of a used or out-of-range block");

endmodule

/* design/mpba_ctrl.sv */
// Controller of the multi-pool block allocator: sequences capture, decode,
// next-fit scan and result hand-off. Drives mpba_dp; uses mpba_pkg.
module mpba_ctrl import mpba_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
						ready_q <= 1'b0;
					end
				end
				S_DECODE: begin
					if (stat.bad_pool || stat.op_free)
						state_q <= S_DONE;
					else
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.cand_free || stat.scan_last)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = ready_q;

	always_comb begin
		cmd = '0;
		cmd.res_code = ST_OK;
		unique case (state_q)
			S_IDLE:
				cmd.cap = s_tvalid && ready_q;
			S_DECODE: begin
				priority if (stat.bad_pool) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_BAD_POOL;
				end else if (stat.op_free) begin
					cmd.set_res     = 1'b1;
					cmd.release_blk = stat.free_ok;
					cmd.res_code    = stat.free_ok ? ST_OK : ST_BAD_BLOCK;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_SCAN: begin
				priority if (stat.cand_free) begin
					cmd.grant    = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_OK;
				end else if (stat.scan_last) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NO_FREE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_DONE:
				cmd.publish = !stat.out_busy;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.grant, cmd.release_blk, cmd.publish, cmd.cap}))
		else $error("overlapping commands");
	a_scan_from_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_init |=> state_q == S_SCAN)
		else $error("scan not entered after init");

endmodule

/* design/multi_pool_block_allocator.sv */
// Multi-pool block allocator: three pools of fixed-size blocks, next-fit
// allocation and checked free. Top level joining mpba_ctrl and mpba_dp.
//
// Usage:
//   Request channel (s_*): s_tuser = {pool[1:0], operation}, s_tdata = block_index.
//   operation 0 allocates from the pool, 1 frees block_index in the pool.
//   Result channel (m_*): m_tuser = status, m_tdata = {pool_full, remaining,
//   granted_index}. Exactly one result per request, in request order.
// Timing:
//   One request at a time. A free or an invalid-pool request passes through
//   decode and then the done state, where its result is loaded into the output
//   register. An allocate goes from decode through the one-block-per-cycle
//   next-fit scan (which probes the block after the last grant first, and at most
//   the pool size in blocks) to the done state. s_tready rises on the edge that
//   loads the result, so a new request is taken only once the last one is through.
// Reset:
//   arst_n clears all bitmaps, last-grant pointers and counts at once; no sweep.
// Stall:
//   The result sits in an output register; a new request is accepted while it
//   waits, and processing holds before hand-off until the register is free.
module multi_pool_block_allocator import mpba_pkg::*; #(
	parameter int SMALL_BLOCKS  = 16,
	parameter int MEDIUM_BLOCKS = 8,
	parameter int LARGE_BLOCKS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // [0] operation, [2:1] pool
	input  logic [7:0]  s_tdata,   // [7:0] block_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic [23:0] m_tdata    // [7:0] granted_index, [16:8] remaining, [17] pool_full
);

	cmd_t  cmd;
	stat_t stat;

	mpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mpba_dp #(
		.SMALL_BLOCKS  (SMALL_BLOCKS),
		.MEDIUM_BLOCKS (MEDIUM_BLOCKS),
		.LARGE_BLOCKS  (LARGE_BLOCKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

/* bench/tb.sv */
// Testbench for multi_pool_block_allocator: directed and random allocate/free
// traffic checked item by item against an in-bench next-fit pool predictor.
// Depends on mpba_pkg and the multi_pool_block_allocator RTL.
`timescale 1ns / 1ps

module tb;
	import mpba_pkg::*;

	localparam int SMALL_N     = 16;
	localparam int MEDIUM_N    = 8;
	localparam int LARGE_N     = 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 300;
	localparam int SETTLE      = 40;

	typedef struct packed {
		status_t    status;
		logic [7:0] granted;
		logic [8:0] remaining;
		logic       full;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;   // [0] operation, [2:1] pool
	logic [7:0]  s_tdata;   // [7:0] block_index
	logic        m_tvalid;
	logic        m_tready;
	logic [1:0]  m_tuser;   // [1:0] status
	logic [23:0] m_tdata;   // [7:0] granted_index, [16:8] remaining, [17] pool_full

	// predictor state
	logic [15:0] used_map [3];
	logic [7:0]  last_grant [3];
	logic [8:0]  in_use [3];

	alloc_result_t pending_results [$];
	int  mismatches;
	int  cycle_count;
	bit  idle_on;
	bit  hold_trigger;

	multi_pool_block_allocator #(
		.SMALL_BLOCKS (SMALL_N),
		.MEDIUM_BLOCKS(MEDIUM_N),
		.LARGE_BLOCKS (LARGE_N)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL multi_pool_block_allocator");
			$finish;
		end
	end

	function automatic int blocks_in(int p);
		case (p)
			0: return SMALL_N;
			1: return MEDIUM_N;
			default: return LARGE_N;
		endcase
	endfunction

	// Next-fit pool model: advance pointer first, then take first free block.
	function automatic alloc_result_t predict_alloc_result(op_t op, pool_t pool,
			logic [7:0] blk);
		alloc_result_t r;
		int p;
		int n;
		int ptr;
		bit found;
		r.status = ST_OK;
		r.granted = '0;
		r.remaining = '0;
		r.full = 1'b1;
		if (pool == POOL_BAD) begin
			r.status = ST_BAD_POOL;
		end else begin
			p = int'(pool);
			n = blocks_in(p);
			if (op == OP_ALLOC) begin
				ptr = int'(last_grant[p]);
				if (ptr >= n)
					ptr = 0;
				found = 1'b0;
				for (int i = 0; i < n && !found; i++) begin
					ptr = (ptr + 1 >= n) ? 0 : ptr + 1;
					if (!used_map[p][ptr])
						found = 1'b1;
				end
				if (found) begin
					used_map[p][ptr] = 1'b1;
					last_grant[p] = ptr[7:0];
					if (in_use[p] < n)
						in_use[p] = in_use[p] + 9'd1;
					r.granted = ptr[7:0];
				end else begin
					r.status = ST_NO_FREE;
				end
			end else begin
				if (blk >= n || !used_map[p][blk]) begin
					r.status = ST_BAD_BLOCK;
				end else begin
					used_map[p][blk] = 1'b0;
					if (in_use[p] > 0)
						in_use[p] = in_use[p] - 9'd1;
				end
			end
			r.remaining = 9'(n) - in_use[p];
			r.full = (r.remaining == 0);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", int'(m_tuser), -1);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status)
					report_mismatch("status", int'(m_tuser), int'(want.status));
				if (m_tdata[7:0] != want.granted)
					report_mismatch("granted_index", int'(m_tdata[7:0]),
						int'(want.granted));
				if (m_tdata[16:8] != want.remaining)
					report_mismatch("remaining", int'(m_tdata[16:8]),
						int'(want.remaining));
				if (m_tdata[17] != want.full)
					report_mismatch("pool_full", int'(m_tdata[17]), int'(want.full));
			end
		end
	end

	// result receiver: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		bit hold_ack;
		hold_left = 0;
		hold_ack = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_ack) begin
				hold_ack = hold_trigger;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!idle_on) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 9);
			end
		end
	end

	// Leaves s_tvalid high after accept; a random gap in the next call or wait_all_results lowers it.
	task automatic send_item(op_t op, pool_t pool, logic [7:0] blk);
		int gap;
		if (idle_on && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= {pool, op};
		s_tdata <= blk;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(predict_alloc_result(op, pool, blk));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_first_grants();
		send_item(OP_ALLOC, POOL_SMALL, 8'hFF);
		send_item(OP_ALLOC, POOL_MEDIUM, 8'h00);
		send_item(OP_ALLOC, POOL_LARGE, 8'hAA);
	endtask

	task automatic test_pool_full();
		repeat (3) send_item(OP_ALLOC, POOL_LARGE, 8'h55);
		send_item(OP_ALLOC, POOL_LARGE, 8'h00);
	endtask

	task automatic test_bad_free();
		send_item(OP_FREE, POOL_LARGE, 8'd4);
		send_item(OP_FREE, POOL_LARGE, 8'd255);
		send_item(OP_FREE, POOL_SMALL, 8'd0);
		send_item(OP_FREE, POOL_MEDIUM, 8'd7);
		send_item(OP_FREE, POOL_LARGE, 8'd2);
		send_item(OP_FREE, POOL_LARGE, 8'd2);
		// pointer steps past the used block 1 to reach the freed block 2
		send_item(OP_ALLOC, POOL_LARGE, 8'd0);
		send_item(OP_FREE, POOL_SMALL, 8'd1);
		send_item(OP_FREE, POOL_MEDIUM, 8'd1);
		send_item(OP_FREE, POOL_SMALL, 8'd16);
	endtask

	task automatic test_bad_pool();
		send_item(OP_ALLOC, POOL_BAD, 8'd0);
		send_item(OP_FREE, POOL_BAD, 8'd255);
		send_item(OP_FREE, POOL_BAD, 8'd0);
	endtask

	task automatic test_random_traffic(int count, int calm_from, int calm_to);
		int alloc_pct;
		int p;
		int n;
		int start;
		int r;
		op_t op;
		pool_t pool;
		logic [7:0] blk;
		alloc_pct = 50;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				r = $urandom_range(2);
				alloc_pct = (r == 0) ? 85 : (r == 1) ? 50 : 20;
			end
			idle_on = !(k >= calm_from && k < calm_to);
			pool = ($urandom_range(99) < 6) ? POOL_BAD : pool_t'(2'($urandom_range(2)));
			op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			blk = 8'($urandom_range(255));
			if (op == OP_FREE && pool != POOL_BAD) begin
				p = int'(pool);
				n = blocks_in(p);
				r = $urandom_range(99);
				if (r < 70) begin
					// prefer a block that is in use
					start = $urandom_range(n - 1);
					blk = start[7:0];
					for (int j = 0; j < n; j++) begin
						if (used_map[p][(start + j) % n]) begin
							blk = 8'((start + j) % n);
							break;
						end
					end
				end else if (r < 85) begin
					blk = 8'($urandom_range(n - 1));
				end
			end
			send_item(op, pool, blk);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		bit saved_idle;
		saved_idle = idle_on;
		idle_on = 1'b0;
		hold_trigger = ~hold_trigger;
		for (int k = 0; k < 8; k++)
			send_item(k[0] ? OP_FREE : OP_ALLOC, pool_t'(2'(k % 3)), 8'($urandom_range(3)));
		idle_on = saved_idle;
	endtask

	task automatic test_drain_pause();
		wait_all_results();
		repeat (5) send_item(OP_ALLOC, POOL_MEDIUM, 8'($urandom_range(255)));
		wait_all_results();
	endtask

	initial begin
		for (int p = 0; p < 3; p++) begin
			used_map[p] = '0;
			last_grant[p] = '0;
			in_use[p] = '0;
		end
		mismatches = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		hold_trigger = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_grants();
		test_pool_full();
		test_bad_free();
		test_bad_pool();
		test_drain_pause();
		test_random_traffic(600, 200, 350);
		test_output_backpressure();
		test_drain_pause();
		test_random_traffic(600, 1000, 1000);
		test_output_backpressure();

		wait_all_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS multi_pool_block_allocator");
		else
			$display("FAIL multi_pool_block_allocator");
		$finish;
	end

endmodule

/* files.f */
design/mpba_pkg.sv
design/mpba_dp.sv
design/mpba_ctrl.sv
design/multi_pool_block_allocator.sv
bench/tb.sv
